/* rtl/grm_pkg.sv */
// ----------------------------------------------------------------------------
// grm_pkg
// shared types, codes and defaults of the grid ray marcher
// ----------------------------------------------------------------------------
`default_nettype none

package grm_pkg;

  // defaults of the top level parameters
  localparam int MAP_SIZE_DEF       = 16;
  localparam int STEPS_PER_UNIT_DEF = 100;
  localparam int MAX_STEPS_DEF      = 2048;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // fixed field geometry
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 12;
  localparam int IDX_W     = 4;
  localparam int STEP_W    = 12;

  // per-step increment split into whole cells and remainder, sized for the
  // smallest step ratio (largest quotient) and the largest one (widest remainder)
  localparam int DQ_W = 5;
  localparam int DR_W = 22;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_LEFT  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [IDX_W-1:0]   cell_row;
    logic [IDX_W-1:0]   cell_col;
    logic               cell_wall;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [IDX_W-1:0]  hit_row;
    logic [IDX_W-1:0]  hit_col;
    logic [1:0]        status;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    in_item_t                item;
    logic signed [DQ_W-1:0]  dq_x;
    logic signed [DQ_W-1:0]  dq_y;
    logic [DR_W-1:0]         dr_x;
    logic [DR_W-1:0]         dr_y;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_CHECK,
    BK_WAIT
  } bk_state_t;

endpackage

`default_nettype wire

/* rtl/grm_ram.sv */
// ----------------------------------------------------------------------------
// grm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module grm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/grm_queue.sv */
// ----------------------------------------------------------------------------
// grm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module grm_queue #(
  parameter int DEPTH = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire grm_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output grm_pkg::cmd_t      head,
  output logic               empty
);

  import grm_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/grm_front.sv */
// ----------------------------------------------------------------------------
// grm_front
// takes items, splits the per-step increment into cells and remainder
// ----------------------------------------------------------------------------
`default_nettype none

module grm_front #(
  parameter int STEPS_PER_UNIT = grm_pkg::STEPS_PER_UNIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire grm_pkg::in_item_t in_data,
  input  wire logic              clearing,
  output logic                   push,
  output grm_pkg::cmd_t          push_data,
  input  wire logic              q_full
);

  import grm_pkg::*;

  localparam int DEN   = STEPS_PER_UNIT << FRAC_BITS;
  localparam int DEN_W = $clog2(DEN);
  localparam int XW    = ((DEN_W > COORD_W) ? DEN_W : COORD_W) + 2;

  fr_state_t               fr_state_r, fr_state_nxt;
  in_item_t                item_r, item_nxt;
  logic signed [XW-1:0]    rx_r, rx_nxt;
  logic signed [XW-1:0]    ry_r, ry_nxt;
  logic signed [DQ_W-1:0]  qx_r, qx_nxt;
  logic signed [DQ_W-1:0]  qy_r, qy_nxt;
  logic signed [COORD_W:0] dx, dy;
  logic                    accept;
  logic                    x_lo, x_hi, y_lo, y_hi, div_done;

  assign accept = in_valid && !in_stall;
  assign dx = $signed({1'b0, in_data.target_x}) - $signed({1'b0, in_data.origin_x});
  assign dy = $signed({1'b0, in_data.target_y}) - $signed({1'b0, in_data.origin_y});

  // remainder window is [0, DEN)
  assign x_lo     = (rx_r < 0);
  assign x_hi     = (rx_r >= XW'(DEN));
  assign y_lo     = (ry_r < 0);
  assign y_hi     = (ry_r >= XW'(DEN));
  assign div_done = !x_lo && !x_hi && !y_lo && !y_hi;

  // next state
  always_comb begin
    fr_state_nxt = fr_state_r;
    unique case (fr_state_r)
      FR_IDLE: begin
        if (accept) begin
          fr_state_nxt = (in_data.opcode == OP_CAST) ? FR_DIV : FR_PUSH;
        end
      end
      FR_DIV: begin
        if (div_done) begin
          fr_state_nxt = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          fr_state_nxt = FR_IDLE;
        end
      end
      default: fr_state_nxt = FR_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall = (fr_state_r != FR_IDLE) || clearing;
    push     = 1'b0;
    item_nxt = item_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    qx_nxt   = qx_r;
    qy_nxt   = qy_r;
    unique case (fr_state_r)
      FR_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          rx_nxt   = XW'(dx);
          ry_nxt   = XW'(dy);
          qx_nxt   = '0;
          qy_nxt   = '0;
        end
      end
      FR_DIV: begin
        // floor division, one cell a cycle per axis
        if (x_lo) begin
          rx_nxt = rx_r + XW'(DEN);
          qx_nxt = qx_r - DQ_W'(1);
        end else if (x_hi) begin
          rx_nxt = rx_r - XW'(DEN);
          qx_nxt = qx_r + DQ_W'(1);
        end
        if (y_lo) begin
          ry_nxt = ry_r + XW'(DEN);
          qy_nxt = qy_r - DQ_W'(1);
        end else if (y_hi) begin
          ry_nxt = ry_r - XW'(DEN);
          qy_nxt = qy_r + DQ_W'(1);
        end
      end
      FR_PUSH: begin
        push = !q_full;
      end
      default: push = 1'b0;
    endcase
  end

  assign push_data.item = item_r;
  assign push_data.dq_x = qx_r;
  assign push_data.dq_y = qy_r;
  assign push_data.dr_x = DR_W'(rx_r);
  assign push_data.dr_y = DR_W'(ry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_state_r <= FR_IDLE;
    end else begin
      fr_state_r <= fr_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
  end

endmodule

`default_nettype wire

/* rtl/grm_back.sv */
// ----------------------------------------------------------------------------
// grm_back
// map store, clearing pass, ray march sequencer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module grm_back #(
  parameter int MAP_SIZE       = grm_pkg::MAP_SIZE_DEF,
  parameter int STEPS_PER_UNIT = grm_pkg::STEPS_PER_UNIT_DEF,
  parameter int MAX_STEPS      = grm_pkg::MAX_STEPS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire grm_pkg::cmd_t head,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  wire logic          out_stall,
  output grm_pkg::out_item_t out_data
);

  import grm_pkg::*;

  localparam int DEN   = STEPS_PER_UNIT << FRAC_BITS;
  localparam int RW    = $clog2(DEN);
  localparam int IW    = $clog2(MAP_SIZE);
  localparam int CW    = IW + 6;
  localparam int CELLS = MAP_SIZE * MAP_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int JW    = $clog2(MAX_STEPS + 1);

  bk_state_t            bk_state_r, bk_state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt;
  logic signed [CW-1:0] cy_r, cy_nxt;
  logic [RW-1:0]        rx_r, rx_nxt;
  logic [RW-1:0]        ry_r, ry_nxt;
  logic [JW-1:0]        j_r, j_nxt;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  out_item_t            res;
  logic                 load;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [0:0]           ram_wdata, ram_rdata;

  logic                 is_write, wr_in_map, off_map, at_limit, is_wall, out_free;
  logic [AW-1:0]        cell_addr, wr_addr;
  logic [RW:0]          sx, sy;
  logic                 cx_carry, cy_carry;
  logic [STEP_W-1:0]    cnt;

  assign is_write  = (head.item.opcode == OP_WRITE);
  assign wr_in_map = (int'(head.item.cell_row) < MAP_SIZE) &&
                     (int'(head.item.cell_col) < MAP_SIZE);
  assign off_map   = (cx_r < 0) || (cx_r >= CW'(MAP_SIZE)) ||
                     (cy_r < 0) || (cy_r >= CW'(MAP_SIZE));
  assign at_limit  = (j_r == JW'(MAX_STEPS));
  assign is_wall   = ram_rdata[0];
  assign out_free  = !out_valid_r || !out_stall;
  assign clearing  = (bk_state_r == BK_CLEAR);

  assign cell_addr = AW'(cx_r[IW-1:0]) * AW'(MAP_SIZE) + AW'(cy_r[IW-1:0]);
  assign wr_addr   = AW'(head.item.cell_row) * AW'(MAP_SIZE) + AW'(head.item.cell_col);

  // next probe point: remainder add with one carry into the cell index
  assign sx       = (RW+1)'(rx_r) + (RW+1)'(head.dr_x);
  assign sy       = (RW+1)'(ry_r) + (RW+1)'(head.dr_y);
  assign cx_carry = (sx >= (RW+1)'(DEN));
  assign cy_carry = (sy >= (RW+1)'(DEN));

  // first probe reports 0, later ones index plus one
  assign cnt = (j_r == '0) ? '0 : STEP_W'(j_r) + STEP_W'(1);

  grm_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    bk_state_nxt = bk_state_r;
    unique case (bk_state_r)
      BK_CLEAR: begin
        if (clr_addr_r == AW'(CELLS - 1)) begin
          bk_state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty && !is_write) begin
          bk_state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (at_limit || off_map) begin
          if (out_free) begin
            bk_state_nxt = BK_IDLE;
          end
        end else begin
          bk_state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (is_wall) begin
          if (out_free) begin
            bk_state_nxt = BK_IDLE;
          end
        end else begin
          bk_state_nxt = BK_CHECK;
        end
      end
      default: bk_state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_r;
    ram_wdata    = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = cell_addr;
    q_pop        = 1'b0;
    load         = 1'b0;
    res          = '0;
    clr_addr_nxt = clr_addr_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    rx_nxt       = rx_r;
    ry_nxt       = ry_r;
    j_nxt        = j_r;
    unique case (bk_state_r)
      BK_CLEAR: begin
        ram_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      BK_IDLE: begin
        if (!q_empty) begin
          if (is_write) begin
            if (out_free) begin
              ram_we     = wr_in_map;
              ram_waddr  = wr_addr;
              ram_wdata  = head.item.cell_wall;
              q_pop      = 1'b1;
              load       = 1'b1;
              res.status = ST_WRITE;
            end
          end else begin
            // start point is the target itself
            cx_nxt = CW'(head.item.target_x[COORD_W-1:FRAC_BITS]);
            cy_nxt = CW'(head.item.target_y[COORD_W-1:FRAC_BITS]);
            rx_nxt = RW'(head.item.target_x[FRAC_BITS-1:0]) * RW'(STEPS_PER_UNIT);
            ry_nxt = RW'(head.item.target_y[FRAC_BITS-1:0]) * RW'(STEPS_PER_UNIT);
            j_nxt  = '0;
          end
        end
      end
      BK_CHECK: begin
        if (at_limit) begin
          if (out_free) begin
            q_pop          = 1'b1;
            load           = 1'b1;
            res.step_count = STEP_W'(j_r);
            res.status     = ST_LIMIT;
          end
        end else if (off_map) begin
          if (out_free) begin
            q_pop          = 1'b1;
            load           = 1'b1;
            res.step_count = cnt;
            res.status     = ST_LEFT;
          end
        end else begin
          ram_re = 1'b1;
        end
      end
      BK_WAIT: begin
        if (is_wall) begin
          if (out_free) begin
            q_pop          = 1'b1;
            load           = 1'b1;
            res.step_count = cnt;
            res.hit_row    = IDX_W'(cx_r[IW-1:0]);
            res.hit_col    = IDX_W'(cy_r[IW-1:0]);
            res.status     = ST_HIT;
          end
        end else begin
          rx_nxt = RW'(cx_carry ? sx - (RW+1)'(DEN) : sx);
          ry_nxt = RW'(cy_carry ? sy - (RW+1)'(DEN) : sy);
          cx_nxt = cx_r + CW'(head.dq_x) + (cx_carry ? CW'(1) : CW'(0));
          cy_nxt = cy_r + CW'(head.dq_y) + (cy_carry ? CW'(1) : CW'(0));
          j_nxt  = j_r + JW'(1);
        end
      end
      default: load = 1'b0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_state_r  <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bk_state_r  <= bk_state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    j_r  <= j_nxt;
    if (load) begin
      out_data_r <= res;
    end
  end

`ifndef ASSERT_OFF
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_CHECK || bk_state_r == BK_WAIT) |-> (j_r <= JW'(MAX_STEPS)))
    else $error("march index beyond step limit");

  a_clear_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_state_r == BK_CLEAR) |-> q_empty)
    else $error("command queued during clearing pass");
`endif

endmodule

`default_nettype wire

/* rtl/grid_ray_march_distance.sv */
// ----------------------------------------------------------------------------
// grid_ray_march_distance
// fixed-step ray marcher over a square one-bit wall map
// flow: the front registers each item; a cast first runs the floor division (FR_DIV), a write
//   goes straight to the push (FR_PUSH); the back writes the map or marches through BK_CHECK
//   and BK_WAIT for each probe, then loads the result register as it leaves
// the front takes no new item until the last one is pushed; the back is bound by one registered map read per probe
// reset: control cleared at once, then a clearing pass over all MAP_SIZE*MAP_SIZE map cells
//   (256 by default) during which no item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_march_distance #(
  parameter int MAP_SIZE       = grm_pkg::MAP_SIZE_DEF,
  parameter int STEPS_PER_UNIT = grm_pkg::STEPS_PER_UNIT_DEF,
  parameter int MAX_STEPS      = grm_pkg::MAX_STEPS_DEF,
  parameter int QUEUE_DEPTH    = grm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // item input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire grm_pkg::in_item_t  in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output grm_pkg::out_item_t      out_data
);

  import grm_pkg::*;

  // front to queue
  logic push;
  cmd_t push_data;
  logic q_full;

  // queue to back
  cmd_t q_head;
  logic q_empty;
  logic q_pop;

  // map clearing in progress, holds the front off
  logic clearing;

  // front: takes items and splits each step increment into whole cells and a
  // remainder so the back only ever adds and compares once per probe
  grm_front #(
    .STEPS_PER_UNIT (STEPS_PER_UNIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .clearing  (clearing),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // short queue so the front can classify the next item while a march runs
  grm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: map writes, probe sequencing and the result register; a command
  // stays at the queue head until its result is loaded
  grm_back #(
    .MAP_SIZE       (MAP_SIZE),
    .STEPS_PER_UNIT (STEPS_PER_UNIT),
    .MAX_STEPS      (MAX_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the grid ray marcher: items are driven through the
// valid/stall input channel, each accepted item is run through a behavioural
// model of the wall map and the march, and every result on the output channel
// is compared field by field, in order, against the model's prediction
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import grm_pkg::*;

  // geometry of the block under test (package defaults)
  localparam int GRID_CELLS = MAP_SIZE_DEF;
  localparam int STEP_DIV   = STEPS_PER_UNIT_DEF;
  localparam int STEP_CAP   = MAX_STEPS_DEF;

  // worst case per item: front split plus the probes of a full march, with margin
  localparam longint WORST_ITEM  = 2 * STEP_CAP + 64;
  // the run never exceeds about 1100 items; taken three times over
  localparam longint CYCLE_LIMIT = 3 * 1100 * WORST_ITEM + 4 * GRID_CELLS * GRID_CELLS;
  // quiet time after the last result, enough for the slowest stray cast
  localparam int     TAIL_CYCLES = 2 * STEP_CAP + 32;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // model state: wall bits indexed by row then column
  logic      wall_map [GRID_CELLS][GRID_CELLS];
  // results still owed by the block, oldest first
  out_item_t pending_results [$];

  int        error_count        = 0;
  int        sender_idle_pct    = 0;
  int        receiver_stall_pct = 0;
  longint    cycle_count        = 0;

  grid_ray_march_distance uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // behavioural model
  // --------------------------------------------------------------------------

  initial begin
    for (int r = 0; r < GRID_CELLS; r++) begin
      for (int c = 0; c < GRID_CELLS; c++) begin
        wall_map[r][c] = 1'b0;
      end
    end
  end

  // cell of one coordinate at march index j, -1 once the point is off the map;
  // the scaled numerator is exact so the floor is exact too
  function automatic int cell_index(longint org, longint tgt, longint j);
    longint num;
    num = tgt * STEP_DIV + j * (tgt - org);
    if (num < 0) return -1;
    num = num / (longint'(STEP_DIV) << FRAC_BITS);
    if (num >= GRID_CELLS) return -1;
    return int'(num);
  endfunction

  // expected result of one item; a write also updates the model map
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t         res;
    int                r;
    int                c;
    logic [STEP_W-1:0] cnt;
    res = '0;
    if (it.opcode == OP_WRITE) begin
      // every row and column fits the map at this size, so the write always lands
      wall_map[it.cell_row][it.cell_col] = it.cell_wall;
      res.status = ST_WRITE;
      return res;
    end
    for (longint j = 0; j < STEP_CAP; j++) begin
      r = cell_index(it.origin_x, it.target_x, j);
      c = cell_index(it.origin_y, it.target_y, j);
      // the target point itself counts as zero, later probes as index plus one
      cnt = (j == 0) ? '0 : STEP_W'(j + 1);
      if (r < 0 || c < 0) begin
        res.step_count = cnt;
        res.status     = ST_LEFT;
        return res;
      end
      if (wall_map[r][c]) begin
        res.step_count = cnt;
        res.hit_row    = IDX_W'(r);
        res.hit_col    = IDX_W'(c);
        res.status     = ST_HIT;
        return res;
      end
    end
    res.step_count = STEP_W'(STEP_CAP);
    res.status     = ST_LIMIT;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // drive one item, optionally after a random gap, and hold it until taken;
  // the prediction is queued at the accepting edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_result(it));
  endtask

  function automatic in_item_t make_write(int row, int col, logic wall);
    in_item_t it;
    it           = '0;
    it.opcode    = OP_WRITE;
    it.cell_row  = IDX_W'(row);
    it.cell_col  = IDX_W'(col);
    it.cell_wall = wall;
    return it;
  endfunction

  function automatic in_item_t make_cast(int ox, int oy, int tx, int ty);
    in_item_t it;
    it          = '0;
    it.opcode   = OP_CAST;
    it.origin_x = COORD_W'(ox);
    it.origin_y = COORD_W'(oy);
    it.target_x = COORD_W'(tx);
    it.target_y = COORD_W'(ty);
    return it;
  endfunction

  // stop sending until the block has returned everything it owes
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // output side: random stall and in-order comparison
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [STEP_W-1:0] want,
                             input logic [STEP_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: step_count %0d status %0d",
                 out_data.step_count, out_data.status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("step_count", want.step_count, out_data.step_count);
          check_field("hit_row",    STEP_W'(want.hit_row), STEP_W'(out_data.hit_row));
          check_field("hit_col",    STEP_W'(want.hit_col), STEP_W'(out_data.hit_col));
          check_field("status",     STEP_W'(want.status),  STEP_W'(out_data.status));
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_ray_march_distance: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // casts over the cleared map: nothing to hit, so rays run off or run out
  task automatic test_empty_map();
    // origin on the target: no movement, full step count
    send_item(make_cast(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // heading up and right until the far edge
    send_item(make_cast(16'h4000, 16'h4000, 16'h8000, 16'h8000));
    // target on the zero edge moving downwards: off the map on the first step
    send_item(make_cast(16'hFFFF, 16'h8000, 16'h0000, 16'h8000));
    // tiny drift that steps into the next cell down and then stays there
    send_item(make_cast(16'h8000, 16'h8001, 16'h8000, 16'h8000));
  endtask

  // write acknowledges at the corners and a set-then-clear
  task automatic test_write_ack();
    send_item(make_write(0, 0, 1'b1));
    send_item(make_write(15, 15, 1'b1));
    send_item(make_write(0, 15, 1'b1));
    send_item(make_write(15, 0, 1'b1));
    send_item(make_write(7, 8, 1'b1));
    send_item(make_write(7, 8, 1'b0));
  endtask

  // walls found on the target cell and further along the ray
  task automatic test_wall_hits();
    // target already a wall, at both coordinate extremes
    send_item(make_cast(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_item(make_cast(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000));
    // diagonal marches into three of the corner walls
    send_item(make_cast(16'h8000, 16'h8000, 16'h9000, 16'h9000));
    send_item(make_cast(16'h8000, 16'h8000, 16'h7000, 16'h7000));
    send_item(make_cast(16'h8000, 16'h8000, 16'h9000, 16'h7000));
    // corner opened again: the same ray now leaves the map
    send_item(make_write(15, 15, 1'b0));
    send_item(make_cast(16'h8000, 16'h8000, 16'h9000, 16'h9000));
    // origin equal to target sitting on a wall
    send_item(make_write(3, 5, 1'b1));
    send_item(make_cast(16'h3800, 16'h5800, 16'h3800, 16'h5800));
  endtask

  // mixed writes and casts with random content under one idling setting
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    in_item_t    it;
    int unsigned pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      it.opcode    = OP_CAST;
      it.cell_row  = IDX_W'($urandom_range(15));
      it.cell_col  = IDX_W'($urandom_range(15));
      it.cell_wall = 1'($urandom_range(1));
      it.origin_x  = COORD_W'($urandom);
      it.origin_y  = COORD_W'($urandom);
      it.target_x  = COORD_W'($urandom);
      it.target_y  = COORD_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 25) begin
        // map edit, biased so the map stays partly open
        it.opcode    = OP_WRITE;
        it.cell_wall = ($urandom_range(99) < 40);
      end else if (pick < 27) begin
        // stationary ray
        it.origin_x = it.target_x;
        it.origin_y = it.target_y;
      end else if (pick < 29) begin
        // very short step: long, slow marches
        it.origin_x = it.target_x ^ COORD_W'($urandom_range(255));
        it.origin_y = it.target_y ^ COORD_W'($urandom_range(255));
      end
      send_item(it);
    end
    // hold off until everything is back before the next setting
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_map();
    test_write_ack();
    test_wall_hits();
    wait_drained();

    // no idling, sender gaps, receiver back-pressure, then both together
    test_random_traffic(250, 0, 0);
    test_random_traffic(250, 69, 0);
    test_random_traffic(250, 0, 69);
    test_random_traffic(250, 20, 20);

    // any stray result would show up during this quiet spell
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("grid_ray_march_distance: match");
    end else begin
      $display("grid_ray_march_distance: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
